/* src/crc8wfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-8 word frame checker package
// Request types, CRC constants and the unrolled CRC-8 byte update.
// ----------------------------------------------------------------------------
package crc8wfc_pkg;

  localparam logic [7:0]  CrcPoly     = 8'h31;
  localparam logic [7:0]  CrcInit     = 8'hFF;
  localparam logic [15:0] ReadyWord   = 16'h0001;
  localparam logic [1:0]  CrcSlot     = 2'd2;   // third byte of each word group
  localparam logic [2:0]  MeasLastWd  = 3'd5;   // last word of a measurement reply
  localparam logic [2:0]  ReadyLastWd = 3'd0;   // only word of a ready reply
  localparam int unsigned PayloadDepth = 12;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       reply_kind;
  } in_req_t;

  typedef struct packed {
    logic        kind_done;
    logic        crc_ok;
    logic        data_ready;
    logic [31:0] co2_bits;
    logic [31:0] temperature_bits;
    logic [31:0] humidity_bits;
  } out_req_t;

  // MSB-first CRC-8 over one byte, no final XOR
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/crc8wfc_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Capture one byte request; hold it until the frame stage can take it.
// ----------------------------------------------------------------------------
module crc8wfc_in_reg import crc8wfc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_req_t in_req_i,
  input  logic    drain_ok_i,
  output logic    item_valid_o,
  output in_req_t item_o
);

  logic    valid_q, valid_d;
  in_req_t req_q;
  logic    accept;
  logic    fire;

  assign fire       = valid_q && drain_ok_i;
  assign in_stall_o = valid_q && !drain_ok_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  assign item_valid_o = fire;
  assign item_o       = req_q;

endmodule

/* src/crc8wfc_frame.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame tracker
// Track position and running CRC, store data bytes, form the frame result.
// ----------------------------------------------------------------------------
module crc8wfc_frame import crc8wfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  in_req_t  item_i,
  output logic     res_valid_o,
  output out_req_t res_o
);

  logic [1:0] slot_q, slot_d;
  logic [2:0] word_q, word_d;
  logic [7:0] crc_q, crc_d;
  logic       kind_q, kind_d;
  logic       mis_q, mis_d;
  logic [7:0] payload_q [PayloadDepth];

  logic [1:0] slot_c;
  logic [2:0] word_c;
  logic [7:0] crc_c;
  logic       mis_c;
  logic       is_data;
  logic       last;
  logic [3:0] wr_idx;

  always_comb begin
    // a start byte restarts the frame in place
    kind_d = item_i.frame_start ? item_i.reply_kind : kind_q;
    slot_c = item_i.frame_start ? 2'd0 : slot_q;
    word_c = item_i.frame_start ? 3'd0 : word_q;
    crc_c  = item_i.frame_start ? CrcInit : crc_q;
    mis_c  = item_i.frame_start ? 1'b0 : mis_q;

    is_data = (slot_c != CrcSlot);
    wr_idx  = {word_c, slot_c[0]};
    last    = !is_data && (word_c == (kind_d ? MeasLastWd : ReadyLastWd));

    if (is_data) begin
      crc_d = crc8_byte(crc_c, item_i.rx_byte);
      mis_d = mis_c;
    end else begin
      crc_d = CrcInit;
      mis_d = mis_c || (item_i.rx_byte != crc_c);
    end

    if (last) begin
      slot_d = 2'd0;
      word_d = 3'd0;
    end else if (!is_data) begin
      slot_d = 2'd0;
      word_d = word_c + 3'd1;
    end else begin
      slot_d = slot_c + 2'd1;
      word_d = word_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 2'd0;
      word_q <= 3'd0;
      crc_q  <= CrcInit;
      kind_q <= 1'b0;
      mis_q  <= 1'b0;
    end else if (item_valid_i) begin
      slot_q <= slot_d;
      word_q <= word_d;
      crc_q  <= crc_d;
      kind_q <= kind_d;
      mis_q  <= last ? 1'b0 : mis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i && is_data) begin
      payload_q[wr_idx] <= item_i.rx_byte;
    end
  end

  always_comb begin
    res_valid_o            = item_valid_i && last;
    res_o.kind_done        = kind_d;
    res_o.crc_ok           = !mis_d;
    res_o.data_ready       = 1'b0;
    res_o.co2_bits         = '0;
    res_o.temperature_bits = '0;
    res_o.humidity_bits    = '0;
    if (kind_d) begin
      res_o.co2_bits         = {payload_q[0], payload_q[1], payload_q[2], payload_q[3]};
      res_o.temperature_bits = {payload_q[4], payload_q[5], payload_q[6], payload_q[7]};
      res_o.humidity_bits    = {payload_q[8], payload_q[9], payload_q[10], payload_q[11]};
    end else begin
      res_o.data_ready = !mis_d && ({payload_q[0], payload_q[1]} == ReadyWord);
    end
  end

endmodule

/* src/crc8wfc_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Hold one frame result until the consumer takes it.
// ----------------------------------------------------------------------------
module crc8wfc_out_reg import crc8wfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  out_req_t res_i,
  output logic     free_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  logic     valid_q;
  out_req_t req_q;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      req_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = req_q;

endmodule

/* src/crc8_word_frame_checker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-8 word frame checker core
// Check CRC-8 (poly 0x31, init 0xFF) protected 2-byte words of sensor replies
// and emit one result per ready or measurement frame.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | request
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o | in_req_t: one reply byte
//   out     | output    | out_valid_o/out_stall_i | out_req_t: frame result
//
// One byte per cycle is sustained while the result register is free; a byte
// accepted into the input register passes through the CRC update and frame
// logic, which feed the result register.
// Reset clears position, running CRC, frame kind and the mismatch flag;
// data bytes stay unknown until written.
// A stalled result holds the result register; the byte in the input register
// then waits, and in_stall_o rises while that register is full.
// ----------------------------------------------------------------------------
module crc8_word_frame_checker_core import crc8wfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  logic     out_free;
  logic     item_valid;
  in_req_t  item;
  logic     res_valid;
  out_req_t res;

  // Capture bytes; advance only when the result register has room.
  crc8wfc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .drain_ok_i   (out_free),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Update frame position and CRC, store data bytes, build the result.
  crc8wfc_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Hold the finished result until taken.
  crc8wfc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

/* tb/frame_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame result checker
// Watch both channels of the CRC-8 word frame checker. Predict each frame
// result from the accepted reply bytes and compare it with what comes out.
// ----------------------------------------------------------------------------
module frame_result_checker import crc8wfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  in_req_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  out_req_t out_req_i,
  output int       fail_count_o,
  output int       pending_o,
  output int       results_o,
  output int       crc_errors_o
);

  localparam int unsigned ReadyLen  = 3;
  localparam int unsigned MeasLen   = 18;
  localparam int unsigned ShownFail = 10;

  // predicted frame state
  logic [4:0] frame_pos;
  logic [7:0] word_crc;
  logic       cur_kind;
  logic       crc_bad;
  logic [7:0] data_bytes [PayloadDepth];

  out_req_t   frame_results_q [$];

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    return c;
  endfunction

  function automatic string show(input out_req_t r);
    return $sformatf("kind=%0b crc_ok=%0b ready=%0b co2=%08h temp=%08h hum=%08h",
                     r.kind_done, r.crc_ok, r.data_ready, r.co2_bits,
                     r.temperature_bits, r.humidity_bits);
  endfunction

  // advance the frame by one reply byte, queue a result on the last byte
  task automatic absorb_byte(input in_req_t r);
    int unsigned flen;
    int unsigned pos;
    logic [3:0]  idx;
    out_req_t    res;
    if (r.frame_start) begin
      frame_pos = '0;
      word_crc  = CrcInit;
      crc_bad   = 1'b0;
      cur_kind  = r.reply_kind;
    end
    flen = cur_kind ? MeasLen : ReadyLen;
    pos  = {27'd0, frame_pos};
    if (pos >= flen) begin
      pos      = 0;
      word_crc = CrcInit;
      crc_bad  = 1'b0;
    end
    if (pos % 3 != CrcSlot) begin
      word_crc = crc_step(word_crc, r.rx_byte);
      idx = 4'((pos / 3) * 2 + pos % 3);
      if (idx < PayloadDepth) data_bytes[idx] = r.rx_byte;
    end else begin
      if (r.rx_byte != word_crc) crc_bad = 1'b1;
      word_crc = CrcInit;
    end
    if (pos + 1 < flen) begin
      frame_pos = 5'(pos + 1);
    end else begin
      res = '0;
      res.kind_done = cur_kind;
      res.crc_ok    = !crc_bad;
      if (cur_kind) begin
        res.co2_bits         = {data_bytes[0], data_bytes[1], data_bytes[2], data_bytes[3]};
        res.temperature_bits = {data_bytes[4], data_bytes[5], data_bytes[6], data_bytes[7]};
        res.humidity_bits    = {data_bytes[8], data_bytes[9], data_bytes[10], data_bytes[11]};
      end else begin
        res.data_ready = !crc_bad && ({data_bytes[0], data_bytes[1]} == ReadyWord);
      end
      frame_results_q.push_back(res);
      frame_pos = '0;
      word_crc  = CrcInit;
      crc_bad   = 1'b0;
    end
  endtask

  task automatic compare_result(input out_req_t got);
    out_req_t want;
    results_o++;
    if (!got.crc_ok) crc_errors_o++;
    if (frame_results_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= ShownFail)
        $display("%0t: result with none expected: %s", $time, show(got));
    end else begin
      want = frame_results_q.pop_front();
      if (got.kind_done !== want.kind_done || got.crc_ok !== want.crc_ok ||
          got.data_ready !== want.data_ready || got.co2_bits !== want.co2_bits ||
          got.temperature_bits !== want.temperature_bits ||
          got.humidity_bits !== want.humidity_bits) begin
        fail_count_o++;
        if (fail_count_o <= ShownFail) begin
          $display("%0t: result %0d mismatch", $time, results_o);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos    = '0;
      word_crc     = CrcInit;
      cur_kind     = 1'b0;
      crc_bad      = 1'b0;
      frame_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      crc_errors_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) compare_result(out_req_i);
      if (in_valid_i && !in_stall_i) absorb_byte(in_req_i);
      pending_o = frame_results_q.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-8 word frame checker testbench
// Drive ready and measurement reply frames (well formed, corrupted, cut
// short, unstarted, plus loose noise bytes) with random gaps on both sides
// and one long receiver hold-off. A checker beside the block predicts and
// compares every frame result; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import crc8wfc_pkg::*;

  localparam int unsigned ReadyLen      = 3;
  localparam int unsigned MeasLen       = 18;
  localparam int unsigned RandomBytes   = 900;
  localparam int unsigned SqueezeAt     = 300;   // byte count that triggers the hold-off
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned CycleLimit    = 400000;

  typedef enum logic [1:0] {FillRandom, FillZero, FillOnes, FillReadyWord} fill_e;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_req;

  int fail_count;
  int pending;
  int results;
  int crc_errors;

  int unsigned bytes_sent;
  bit          burst_mode;      // no sender gaps while set
  bit          squeeze_start;   // asks the receiver for its long hold-off

  crc8_word_frame_checker_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  frame_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_req_i    (out_req),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .crc_errors_o (crc_errors)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // Seal a word the way the sensor does: bit-serial CRC-8 over both bytes.
  function automatic logic [7:0] word_seal(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0]  c;
    logic [15:0] w;
    c = CrcInit;
    w = {hi, lo};
    for (int i = 15; i >= 0; i--) begin
      c = (c[7] ^ w[i]) ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Offer one request at the falling edge and hold it until the block takes it.
  // Returns at the falling edge after acceptance, so valid stays up into the
  // next request when no gap is drawn.
  task automatic send_byte(input logic [7:0] b, input logic start, input logic kind);
    int unsigned idle;
    in_req_t     req;
    idle = burst_mode ? 0 : pick_gap();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    req.rx_byte     = b;
    req.frame_start = start;
    req.reply_kind  = kind;
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Send the first nbytes of a frame. Each word is followed by its seal; words
  // flagged in bad_words get a corrupted seal. reply_kind only carries meaning
  // on the start byte, so randomize it everywhere else.
  task automatic send_frame(input logic kind, input logic lead_start,
                            input logic [5:0] bad_words, input fill_e fill,
                            input int unsigned nbytes);
    logic [7:0]  grp [3];
    int unsigned words;
    int unsigned sent;
    logic        first;
    words = kind ? 6 : 1;
    sent  = 0;
    for (int w = 0; w < words; w++) begin
      case (fill)
        FillZero: begin
          grp[0] = 8'h00;
          grp[1] = 8'h00;
        end
        FillOnes: begin
          grp[0] = 8'hFF;
          grp[1] = 8'hFF;
        end
        FillReadyWord: begin
          {grp[0], grp[1]} = ReadyWord;
        end
        default: begin
          grp[0] = 8'($urandom);
          grp[1] = 8'($urandom);
        end
      endcase
      grp[2] = word_seal(grp[0], grp[1]);
      if (bad_words[w]) grp[2] ^= 8'($urandom_range(1, 255));
      for (int k = 0; k < 3; k++) begin
        if (sent < nbytes) begin
          first = lead_start && (sent == 0);
          send_byte(grp[k], first, first ? kind : 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  // Receiver: random stall bursts between calm stretches, and once a long
  // hold-off so that the result register backs up into the input side.
  initial begin : receiver
    int unsigned hold;
    int unsigned calm;
    bit          squeeze_done;
    hold         = 0;
    calm         = 0;
    squeeze_done = 1'b0;
    out_stall    = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_start && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold = HoldOffCycles;
      end else if (hold == 0 && calm == 0) begin
        hold = pick_gap();
        calm = ($urandom_range(0, 99) < 10) ? 150 : $urandom_range(1, 20);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (calm > 0) calm--;
      end
    end
  end

  // Hard stop in case the block hangs or results go missing.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still owed", cycles, pending);
    $display("** crc8_word_frame_checker_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned pick;
    int unsigned nbytes;
    logic        kind;
    logic        lead;
    logic        last_kind;
    logic        need_start;
    logic [5:0]  bad;
    fill_e       fill;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req        = '0;
    bytes_sent    = 0;
    burst_mode    = 1'b0;
    squeeze_start = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed frames -----------------------------------------------------
    // No start after reset: the block treats it as a ready reply; good seal.
    send_frame(1'b0, 1'b0, 6'b000000, FillReadyWord, ReadyLen);
    // Straight on without a start: next ready frame, now with a broken seal.
    send_frame(1'b0, 1'b0, 6'b000001, FillReadyWord, ReadyLen);
    // Cut a ready frame short with a new start in the middle of it.
    send_frame(1'b0, 1'b1, 6'b000000, FillZero, 2);
    // Full measurement of all-ones data with one corrupted word seal.
    send_frame(1'b1, 1'b1, 6'b000100, FillOnes, MeasLen);
    target     = bytes_sent + RandomBytes;
    last_kind  = 1'b1;
    need_start = 1'b0;

    // --- random frames ---------------------------------------------------------
    while (bytes_sent < target) begin
      burst_mode = ($urandom_range(0, 9) == 0);

      // Back-to-back ready frames while the receiver holds off.
      if (!squeeze_start && bytes_sent >= SqueezeAt) begin
        squeeze_start = 1'b1;
        burst_mode    = 1'b1;
        repeat (12) send_frame(1'b0, 1'b1, 6'b000000, FillRandom, ReadyLen);
        last_kind  = 1'b0;
        need_start = 1'b0;
        continue;
      end

      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        // Whole frame, usually started, sometimes chained onto the last one.
        lead = need_start || ($urandom_range(0, 99) < 85);
        kind = lead ? 1'($urandom_range(0, 1)) : last_kind;
        bad  = ($urandom_range(0, 99) < 80) ? 6'b000000 : 6'($urandom_range(1, 63));
        if (!kind) bad &= 6'b000001;
        if (!kind) begin
          fill = ($urandom_range(0, 99) < 40) ? FillReadyWord : FillRandom;
        end else if ($urandom_range(0, 99) < 6) begin
          fill = $urandom_range(0, 1) ? FillZero : FillOnes;
        end else begin
          fill = FillRandom;
        end
        send_frame(kind, lead, bad, fill, kind ? MeasLen : ReadyLen);
        last_kind  = kind;
        need_start = 1'b0;
      end else if (pick < 86) begin
        // Truncated frame; the next one has to restart it.
        kind   = 1'($urandom_range(0, 1));
        nbytes = $urandom_range(1, (kind ? MeasLen : ReadyLen) - 1);
        send_frame(kind, 1'b1, 6'($urandom_range(0, 63)), FillRandom, nbytes);
        need_start = 1'b1;
      end else begin
        // Loose bytes with random start and kind bits.
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom), ($urandom_range(0, 99) < 25), 1'($urandom_range(0, 1)));
        end
        need_start = 1'b1;
      end
    end

    // --- drain -----------------------------------------------------------------
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Sent %0d reply bytes as ready, measurement, cut-short and noise frames",
             bytes_sent);
    $display("Checked %0d frame results, %0d of them flagged a CRC error", results,
             crc_errors);
    if (fail_count == 0) begin
      $display("** crc8_word_frame_checker_core: PASSED **");
    end else begin
      $display("** crc8_word_frame_checker_core: FAILED **");
    end
    $finish;
  end

endmodule
